// ===== src/mpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpmc_pkg
// Shared commands, status codes, beat payload types and saturating helpers.
// ----------------------------------------------------------------------------
package mpmc_pkg;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_END   = 3'd2;
  localparam logic [2:0] CMD_BUILD = 3'd3;
  localparam logic [2:0] CMD_SCAN  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] symbol;
    logic       last_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] matches_here;
    logic [31:0] match_total;
    logic        text_done;
  } out_beat_t;

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== src/mpmc_if.sv =====
// ----------------------------------------------------------------------------
// mpmc_in_if / mpmc_out_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
interface mpmc_in_if;
  logic               valid;
  logic               ready;
  mpmc_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpmc_out_if;
  logic                valid;
  logic                ready;
  mpmc_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mpmc_ram.sv =====
// ----------------------------------------------------------------------------
// mpmc_ram
// Single-port synchronous memory, registered read.
// ----------------------------------------------------------------------------
module mpmc_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // read before write (old data), read registered
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== src/multi_pattern_match_counter_unit.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_match_counter_unit
// Aho-Corasick keyword counter: trie, failure links and hit counts in RAMs.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | command, symbol, last_of_text
// out_    | out | status, matches_here, match_total, text_done
// an add whose symbol is outside the alphabet leaves the trie unchanged;
//   scan and build follow failure links, and build visits every goto entry
//   of each node in turn on the single-port goto RAM
// reset and clear run a sweep over every entry of the goto RAM
//   (one entry a cycle, hit counts cleared alongside) before beats are taken
// one beat in flight; a new beat is taken only once the previous result
//   has left; the result register holds while out_ready is low
module multi_pattern_match_counter_unit #(
  parameter int ALPHABET  = 32,
  parameter int MAX_NODES = 256
) (
  input  logic clk,
  input  logic rst_n,
  mpmc_in_if.sink    in_ch,
  mpmc_out_if.source out_ch
);

  localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int SW = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int GW = NW + SW;
  localparam int CW = NW + 1;

  localparam logic [4:0] S_SWEEP = 5'd0,  S_IDLE = 5'd1,  S_ADD_RD = 5'd2,
                         S_ADD_CK = 5'd3, S_END_RD = 5'd4, S_END_WR = 5'd5,
                         S_SC_RD = 5'd6,  S_SC_CK = 5'd7,  S_SC_FL = 5'd8,
                         S_SC_FW = 5'd9,  S_SC_HR = 5'd10, S_SC_HW = 5'd11,
                         S_B_U = 5'd12,   S_B_C = 5'd13,   S_B_CK = 5'd14,
                         S_B_FL = 5'd15,  S_B_FW = 5'd16,  S_B_FC = 5'd17,
                         S_B_T = 5'd18,   S_B_HV = 5'd19,  S_B_HT = 5'd20,
                         S_B_WR = 5'd21,  S_OUT = 5'd22,   S_B_UW = 5'd23,
                         S_B_HVW = 5'd24, S_B_HTW = 5'd25;

  logic [4:0]    state_r, state_nxt;
  logic [GW-1:0] sweep_r, sweep_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [NW-1:0] cur_r, cur_nxt, mnode_r, mnode_nxt;
  logic [31:0]   total_r, total_nxt;
  logic          built_r, built_nxt;
  logic [4:0]    sym_r, sym_nxt;
  logic          last_r, last_nxt;
  logic [NW-1:0] u_r, u_nxt, v_r, v_nxt, f_r, f_nxt, t_r, t_nxt;
  logic [SW:0]   c_r, c_nxt;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [15:0]   hv_r, hv_nxt;
  mpmc_pkg::out_beat_t res_r, res_nxt;
  logic          ovalid_r, ovalid_nxt;

  // memories
  logic          g_we, f_we, h_we, q_we;
  logic [GW-1:0] g_a;
  logic [NW-1:0] g_wd, g_rd, f_a, f_wd, f_rd, h_a, q_a, q_wd, q_rd;
  logic [15:0]   h_wd, h_rd;

  mpmc_ram #(.AW(GW), .DW(NW)) u_goto (.clk, .we(g_we), .addr(g_a), .wdata(g_wd),
                                      .rdata(g_rd));
  mpmc_ram #(.AW(NW), .DW(NW)) u_fail (.clk, .we(f_we), .addr(f_a), .wdata(f_wd),
                                      .rdata(f_rd));
  mpmc_ram #(.AW(NW), .DW(16)) u_hits (.clk, .we(h_we), .addr(h_a), .wdata(h_wd),
                                      .rdata(h_rd));
  mpmc_ram #(.AW(NW), .DW(NW)) u_bfsq (.clk, .we(q_we), .addr(q_a), .wdata(q_wd),
                                      .rdata(q_rd));

  logic sym_ok;
  assign sym_ok = (32'(sym_r) < ALPHABET);

  function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] n, input logic [4:0] s);
    return {n, SW'(s)};
  endfunction

  assign in_ch.ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  // sequencer
  always_comb begin
    state_nxt = state_r; sweep_nxt = sweep_r; used_nxt = used_r; cur_nxt = cur_r;
    mnode_nxt = mnode_r; total_nxt = total_r; built_nxt = built_r;
    sym_nxt = sym_r; last_nxt = last_r;
    u_nxt = u_r; v_nxt = v_r; f_nxt = f_r; t_nxt = t_r; c_nxt = c_r;
    head_nxt = head_r; tail_nxt = tail_r; hv_nxt = hv_r;
    res_nxt = res_r; ovalid_nxt = ovalid_r;
    g_we = 1'b0; g_a = sweep_r; g_wd = '0;
    f_we = 1'b0; f_a = '0; f_wd = '0;
    h_we = 1'b0; h_a = '0; h_wd = '0;
    q_we = 1'b0; q_a = '0; q_wd = '0;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_SWEEP: begin
        g_we = 1'b1; g_a = sweep_r;
        h_we = 1'b1; h_a = sweep_r[NW-1:0];
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          sym_nxt = in_ch.data.symbol;
          last_nxt = in_ch.data.last_of_text;
          res_nxt = '{status: mpmc_pkg::ST_OK, matches_here: 16'd0,
                      match_total: total_r, text_done: 1'b0};
          state_nxt = S_OUT;
          case (in_ch.data.command)
            mpmc_pkg::CMD_CLEAR: begin
              used_nxt = CW'(1); cur_nxt = '0; mnode_nxt = '0;
              total_nxt = '0; built_nxt = 1'b0; sweep_nxt = '0;
              res_nxt.match_total = '0;
              state_nxt = S_SWEEP;
              ovalid_nxt = 1'b1;
            end
            mpmc_pkg::CMD_ADD:   if (!built_r) state_nxt = S_ADD_RD;
            mpmc_pkg::CMD_END:   if (!built_r) state_nxt = S_END_RD;
            mpmc_pkg::CMD_BUILD:
              if (!built_r) begin
                f_we = 1'b1; f_a = '0; q_we = 1'b1; q_a = '0;
                head_nxt = '0; tail_nxt = CW'(1); state_nxt = S_B_U;
              end
            mpmc_pkg::CMD_SCAN: begin
              if (!built_r) res_nxt.status = mpmc_pkg::ST_EARLY;
              else state_nxt = S_SC_RD;
            end
            default: ;
          endcase
        end
      end
      S_ADD_RD: begin
        g_a = gaddr(cur_r, sym_r);
        state_nxt = sym_ok ? S_ADD_CK : S_OUT;
      end
      S_ADD_CK: begin
        if (g_rd != '0) begin
          cur_nxt = g_rd; state_nxt = S_OUT;
        end else if (used_r >= CW'(MAX_NODES)) begin
          res_nxt.status = mpmc_pkg::ST_FULL; state_nxt = S_OUT;
        end else begin
          g_we = 1'b1; g_a = gaddr(cur_r, sym_r); g_wd = used_r[NW-1:0];
          h_we = 1'b1; h_a = used_r[NW-1:0];
          cur_nxt = used_r[NW-1:0]; used_nxt = used_r + 1'b1; state_nxt = S_OUT;
        end
      end
      S_END_RD: begin h_a = cur_r; state_nxt = S_END_WR; end
      S_END_WR: begin
        h_we = 1'b1; h_a = cur_r; h_wd = mpmc_pkg::sat16(h_rd, 16'd1);
        cur_nxt = '0; state_nxt = S_OUT;
      end
      // scan: fall back along failure links until a goto exists or the root is reached
      S_SC_RD: begin
        g_a = gaddr(mnode_r, sym_r);
        state_nxt = S_SC_CK;
      end
      S_SC_CK: begin
        if (!sym_ok || g_rd == '0) begin
          if (mnode_r == '0) begin
            mnode_nxt = '0; state_nxt = S_SC_HR;
          end else begin
            state_nxt = S_SC_FL;
          end
        end else begin
          mnode_nxt = g_rd; state_nxt = S_SC_HR;
        end
      end
      S_SC_FL: begin f_a = mnode_r; state_nxt = S_SC_FW; end
      S_SC_FW: begin mnode_nxt = f_rd; state_nxt = S_SC_RD; end
      S_SC_HR: begin h_a = mnode_r; state_nxt = S_SC_HW; end
      S_SC_HW: begin
        res_nxt.matches_here = h_rd;
        res_nxt.match_total  = mpmc_pkg::sat32(total_r, h_rd);
        total_nxt = mpmc_pkg::sat32(total_r, h_rd);
        if (last_r) begin
          res_nxt.text_done = 1'b1; total_nxt = '0; mnode_nxt = '0;
        end
        state_nxt = S_OUT;
      end
      // build: breadth-first over the queue
      S_B_U: begin
        if (head_r == tail_r) begin
          built_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          q_a = head_r[NW-1:0]; head_nxt = head_r + 1'b1; state_nxt = S_B_UW;
        end
      end
      S_B_UW: begin u_nxt = q_rd; c_nxt = '0; state_nxt = S_B_C; end
      S_B_C: begin
        if (c_r == (SW+1)'(ALPHABET)) state_nxt = S_B_U;
        else begin g_a = {u_r, c_r[SW-1:0]}; state_nxt = S_B_CK; end
      end
      S_B_CK: begin
        if (g_rd == '0) begin
          c_nxt = c_r + 1'b1; state_nxt = S_B_C;
        end else begin
          v_nxt = g_rd;
          if (u_r == '0) begin t_nxt = '0; state_nxt = S_B_HV; end
          else begin f_a = u_r; state_nxt = S_B_FW; end
        end
      end
      S_B_FW: begin f_nxt = f_rd; state_nxt = S_B_FC; end
      S_B_FC: begin g_a = {f_r, c_r[SW-1:0]}; state_nxt = S_B_T; end
      S_B_T: begin
        if (f_r != '0 && g_rd == '0) begin
          f_a = f_r; state_nxt = S_B_FW;
        end else begin
          t_nxt = (g_rd == v_r) ? '0 : g_rd; state_nxt = S_B_HV;
        end
      end
      S_B_FL: state_nxt = S_B_HV;
      S_B_HV: begin
        f_we = 1'b1; f_a = v_r; f_wd = t_r;
        h_a = v_r; state_nxt = S_B_HVW;
      end
      S_B_HVW: begin hv_nxt = h_rd; state_nxt = S_B_HT; end
      S_B_HT: begin h_a = t_r; state_nxt = S_B_HTW; end
      S_B_HTW: begin
        h_we = 1'b1; h_a = v_r; h_wd = mpmc_pkg::sat16(hv_r, h_rd);
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        if (tail_r < CW'(MAX_NODES)) begin
          q_we = 1'b1; q_a = tail_r[NW-1:0]; q_wd = v_r; tail_nxt = tail_r + 1'b1;
        end
        c_nxt = c_r + 1'b1; state_nxt = S_B_C;
      end
      S_OUT: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP; sweep_r <= '0; used_r <= CW'(1); cur_r <= '0;
      mnode_r <= '0; total_r <= '0; built_r <= 1'b0; ovalid_r <= 1'b0;
      head_r <= '0; tail_r <= '0;
    end else begin
      state_r <= state_nxt; sweep_r <= sweep_nxt; used_r <= used_nxt;
      cur_r <= cur_nxt; mnode_r <= mnode_nxt; total_r <= total_nxt;
      built_r <= built_nxt; ovalid_r <= ovalid_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
    end
    sym_r <= sym_nxt; last_r <= last_nxt;
    u_r <= u_nxt; v_r <= v_nxt; f_r <= f_nxt; t_r <= t_nxt; c_r <= c_nxt;
    hv_r <= hv_nxt; res_r <= res_nxt;
  end

  // checks
  a_not_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_NODES) && used_r != '0) else $error("node count out of range");
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_r} < used_r) else $error("cursor beyond used nodes");

endmodule

// ===== dv/mpmc_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpmc_scoreboard
// Watches the command and result channels, runs its own keyword automaton
// on every accepted command beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module mpmc_scoreboard (
  input  logic clk,
  input  logic rst_n,
  mpmc_in_if   in_ch,
  mpmc_out_if  out_ch,
  output int   mismatches,
  output int   awaited,
  output int   results_seen,
  output int   texts_closed
);

  localparam int SYMS  = 32;
  localparam int NODES = 256;

  // automaton state
  logic [7:0]  trie     [0:NODES*SYMS-1];
  logic [7:0]  fail_to  [0:NODES-1];
  logic [15:0] hits     [0:NODES-1];
  int          used;
  logic [7:0]  cursor;
  logic [7:0]  at_node;
  logic [31:0] total;
  logic        linked;

  mpmc_pkg::out_beat_t results_due [$];

  function automatic logic [15:0] plus16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > 17'h0FFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [7:0] step_to(input logic [7:0] node, input logic [4:0] sym);
    return trie[{node, sym}];
  endfunction

  task automatic wipe();
    foreach (trie[i]) trie[i] = '0;
    foreach (fail_to[i]) fail_to[i] = '0;
    foreach (hits[i]) hits[i] = '0;
    used    = 1;
    cursor  = '0;
    at_node = '0;
    total   = '0;
    linked  = 1'b0;
  endtask

  // breadth-first failure links with hit folding
  task automatic link_up();
    logic [7:0] pending_nodes [$];
    int         pushed;
    logic [7:0] u, v, f, t;
    fail_to[0] = '0;
    pending_nodes.push_back(8'd0);
    pushed = 1;
    while (pending_nodes.size() > 0) begin
      u = pending_nodes.pop_front();
      for (int c = 0; c < SYMS; c++) begin
        v = step_to(u, c[4:0]);
        if (v == 0) continue;
        if (u == 0) begin
          t = '0;
        end else begin
          f = fail_to[u];
          while (f != 0 && step_to(f, c[4:0]) == 0) f = fail_to[f];
          t = step_to(f, c[4:0]);
          if (t == v) t = '0;
        end
        fail_to[v] = t;
        hits[v] = plus16(hits[v], hits[t]);
        if (pushed < NODES) begin
          pending_nodes.push_back(v);
          pushed++;
        end
      end
    end
    linked = 1'b1;
  endtask

  task automatic predict(input mpmc_pkg::in_beat_t b);
    mpmc_pkg::out_beat_t r;
    logic [7:0]  nxt;
    logic [32:0] s;
    r = '0;
    case (b.command)
      mpmc_pkg::CMD_CLEAR: wipe();
      mpmc_pkg::CMD_ADD: if (!linked) begin
        nxt = step_to(cursor, b.symbol);
        if (nxt == 0 && used >= NODES) begin
          r.status = mpmc_pkg::ST_FULL;
        end else begin
          if (nxt == 0) begin
            nxt = used[7:0];
            used++;
            trie[{cursor, b.symbol}] = nxt;
            hits[nxt] = '0;
          end
          cursor = nxt;
        end
      end
      mpmc_pkg::CMD_END: if (!linked) begin
        hits[cursor] = plus16(hits[cursor], 16'd1);
        cursor = '0;
      end
      mpmc_pkg::CMD_BUILD: if (!linked) link_up();
      mpmc_pkg::CMD_SCAN: if (!linked) begin
        r.status = mpmc_pkg::ST_EARLY;
      end else begin
        while (at_node != 0 && step_to(at_node, b.symbol) == 0) at_node = fail_to[at_node];
        at_node = step_to(at_node, b.symbol);
        r.matches_here = hits[at_node];
        s = {1'b0, total} + {17'd0, hits[at_node]};
        total = s[32] ? 32'hFFFF_FFFF : s[31:0];
        if (b.last_of_text) begin
          r.text_done   = 1'b1;
          r.match_total = total;
          total   = '0;
          at_node = '0;
        end
      end
      default: ;
    endcase
    if (!r.text_done) r.match_total = total;
    results_due.push_back(r);
  endtask

  // per-edge bookkeeping: command beat first, then result beat
  always @(posedge clk) begin
    mpmc_pkg::out_beat_t want;
    mpmc_pkg::out_beat_t got;
    if (!rst_n) begin
      wipe();
      results_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) predict(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (got.text_done) texts_closed++;
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: %p", got);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.matches_here !== want.matches_here) begin
            $error("matches_here: expected %0d, got %0d", want.matches_here, got.matches_here);
            mismatches++;
          end
          if (got.match_total !== want.match_total) begin
            $error("match_total: expected %0d, got %0d", want.match_total, got.match_total);
            mismatches++;
          end
          if (got.text_done !== want.text_done) begin
            $error("text_done: expected %0d, got %0d", want.text_done, got.text_done);
            mismatches++;
          end
        end
      end
    end
    awaited <= results_due.size();
  end

  initial begin
    mismatches   = 0;
    awaited      = 0;
    results_seen = 0;
    texts_closed = 0;
  end

endmodule

// ===== dv/tb_multi_pattern_match_counter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_pattern_match_counter_unit
// Drives keyword sessions (clear, add/end keywords, build, scan texts) with
// random gaps and back-pressure; the scoreboard predicts and checks results.
// ----------------------------------------------------------------------------
module tb_multi_pattern_match_counter_unit;

  // unused command codes the block must ignore
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  logic clk;
  logic rst_n;
  int   mismatches, awaited, results_seen, texts_closed;
  int   beats_sent;
  bit   no_gaps;

  mpmc_in_if  in_ch();
  mpmc_out_if out_ch();

  multi_pattern_match_counter_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mpmc_scoreboard u_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .results_seen (results_seen),
    .texts_closed (texts_closed)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // one command beat, with a random gap in front
  task automatic send(input logic [2:0] cmd, input int sym, input int last);
    mpmc_pkg::in_beat_t b;
    int                 gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    b.command      = cmd;
    b.symbol       = sym[4:0];
    b.last_of_text = last[0];
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    if ($urandom_range(0, 99) == 0) no_gaps = !no_gaps;
  endtask

  // hold off until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // keyword session: symbols from a narrow window so keywords overlap
  task automatic session(input int keys, input int max_len, input int span, input int texts);
    int base;
    int len;
    base = $urandom_range(0, 32 - span);
    send(mpmc_pkg::CMD_CLEAR, $urandom, $urandom);
    if ($urandom_range(0, 3) == 0) send(mpmc_pkg::CMD_SCAN, $urandom, $urandom);
    for (int k = 0; k < keys; k++) begin
      len = $urandom_range(0, max_len);
      for (int i = 0; i < len; i++)
        send(mpmc_pkg::CMD_ADD, base + $urandom_range(0, span - 1), $urandom);
      send(mpmc_pkg::CMD_END, $urandom, $urandom);
    end
    send(mpmc_pkg::CMD_BUILD, $urandom, $urandom);
    for (int t = 0; t < texts; t++) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 19))
          0:       send(mpmc_pkg::CMD_ADD, $urandom, $urandom);
          1:       send(mpmc_pkg::CMD_END, $urandom, $urandom);
          2:       send(mpmc_pkg::CMD_BUILD, $urandom, $urandom);
          3:       send(3'(CMD_SPARE5 + $urandom_range(0, 2)), $urandom, $urandom);
          4:       send(mpmc_pkg::CMD_SCAN, $urandom, 0);
          default: send(mpmc_pkg::CMD_SCAN, base + $urandom_range(0, span - 1), 0);
        endcase
      end
      send(mpmc_pkg::CMD_SCAN, base + $urandom_range(0, span - 1), 1);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n       = 1'b0;
    beats_sent  = 0;
    no_gaps     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: early scan, spare codes, extreme symbols, empty keyword
    send(mpmc_pkg::CMD_SCAN, 31, 1);
    send(CMD_SPARE5, 31, 1);
    send(CMD_SPARE6, 0, 0);
    send(CMD_SPARE7, 31, 1);
    send(mpmc_pkg::CMD_ADD, 0, 1);
    send(mpmc_pkg::CMD_ADD, 31, 0);
    send(mpmc_pkg::CMD_END, 0, 1);
    send(mpmc_pkg::CMD_END, 31, 0);
    send(mpmc_pkg::CMD_ADD, 31, 0);
    send(mpmc_pkg::CMD_END, 0, 0);
    send(mpmc_pkg::CMD_ADD, 31, 0);
    send(mpmc_pkg::CMD_END, 0, 0);
    send(mpmc_pkg::CMD_BUILD, 0, 1);
    send(mpmc_pkg::CMD_BUILD, 31, 0);
    send(mpmc_pkg::CMD_ADD, 5, 0);
    send(mpmc_pkg::CMD_END, 5, 0);
    send(mpmc_pkg::CMD_SCAN, 0, 0);
    send(mpmc_pkg::CMD_SCAN, 31, 0);
    send(mpmc_pkg::CMD_SCAN, 31, 0);
    send(mpmc_pkg::CMD_SCAN, 0, 1);
    send(mpmc_pkg::CMD_SCAN, 17, 1);
    drain();

    // fill the node table past its end
    send(mpmc_pkg::CMD_CLEAR, 0, 0);
    for (int i = 0; i < 300; i++) begin
      send(mpmc_pkg::CMD_ADD, $urandom, 0);
      if (i % 25 == 24) send(mpmc_pkg::CMD_END, 0, 0);
    end
    send(mpmc_pkg::CMD_END, 0, 0);
    send(mpmc_pkg::CMD_BUILD, 0, 0);
    for (int i = 0; i < 30; i++) send(mpmc_pkg::CMD_SCAN, $urandom, int'(i % 10 == 9));

    // random sessions
    while (beats_sent < 2000) begin
      session($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(2, 6),
              $urandom_range(2, 6));
    end

    drain();
    repeat (200) @(posedge clk);
    $display("%0d command beats sent, %0d results checked, %0d texts closed",
             beats_sent, results_seen, texts_closed);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
